@@ hw/rtl/trm_pkg.sv @@
// trm_pkg: shared types and constants of the thermal runaway monitor
// status codes, configuration register indexes, register reset values, field widths
// no dependencies
package trm_pkg;

  // field widths
  localparam int unsigned TempW   = 16;
  localparam int unsigned SetW    = 15;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WinW    = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 31;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 8;
  // wide signed width for targets and bands
  localparam int unsigned WideW   = 18;

  // status and mode codes
  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_HEAT     = 3'd1,
    ST_COOL     = 3'd2,
    ST_CONV     = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_JUMP     = 3'd5,
    ST_DIVERGED = 3'd6
  } status_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_JUMP      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONV_TOL      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIVERGE_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEAT_PROGRESS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COOL_PROGRESS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_MS     = 3'd5;

  // register reset values
  localparam logic [SetW-1:0] RST_MAX_JUMP      = 15'd10;
  localparam logic [SetW-1:0] RST_CONV_TOL      = 15'd2;
  localparam logic [SetW-1:0] RST_DIVERGE_LIMIT = 15'd10;
  localparam logic [SetW-1:0] RST_HEAT_PROGRESS = 15'd4;
  localparam logic [SetW-1:0] RST_COOL_PROGRESS = 15'd2;
  localparam logic [WinW-1:0] RST_WINDOW_MS     = 31'd1000;

endpackage

@@ hw/rtl/thermal_runaway_monitor_core.sv @@
// thermal_runaway_monitor_core: heater sample checker, one status per sample
// input register, single-pass update of the mode state, output register
// depends on trm_pkg
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: target_temp, measured_temp, now_ms
//  m_axis    out  tvalid/tready          tdata: status
//  cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one sample per cycle while the status stream is not stalled; a taken request
// passes the input register, then the mode update into the result register
// reset clears the mode state, the configuration to its defaults and both stages
// a stalled result holds the input register; the input stalls only when both
// stages are full, the configuration port is always ready
module thermal_runaway_monitor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trm_pkg::CfgDatW-1:0]   cfg_data_i,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [14:0] target_temp, [30:15] measured_temp, [62:31] now_ms, [63] zero
  input  logic [trm_pkg::InDataW-1:0]   s_axis_tdata,
  // status stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [7:3] zero
  output logic [trm_pkg::OutDataW-1:0]  m_axis_tdata
);
  import trm_pkg::*;

  // configuration registers
  logic [SetW-1:0] max_jump_q, conv_tol_q, div_lim_q, heat_prog_q, cool_prog_q;
  logic [WinW-1:0] window_q;

  // pipeline control and payload
  logic                      s1_valid_q, out_valid_q;
  logic [SetW-1:0]           s1_sp_q;
  logic signed [TempW-1:0]   s1_temp_q;
  logic [TimeW-1:0]          s1_now_q;
  status_e                   out_status_q;
  logic                      s1_adv, in_acc;

  // mode state
  status_e                   mode_q, mode_d;
  logic [SetW-1:0]           prev_sp_q;
  logic signed [TempW-1:0]   prev_temp_q;
  logic signed [WideW-1:0]   prog_tgt_q, prog_tgt_d;
  logic [TimeW-1:0]          deadline_q, deadline_d;

  // combinational update
  logic signed [TempW-1:0]   prev_eff;
  logic signed [WideW-1:0]   t_w, p_w, dlt, adlt, sp_w;
  logic signed [WideW-1:0]   conv_lo, conv_hi, div_lo, div_hi;
  logic [TimeW-1:0]          dl_left;
  logic                      win_over, jump, sp_change, normal_mode;
  status_e                   mode_mid;

  // config write port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jump_q  <= RST_MAX_JUMP;
      conv_tol_q  <= RST_CONV_TOL;
      div_lim_q   <= RST_DIVERGE_LIMIT;
      heat_prog_q <= RST_HEAT_PROGRESS;
      cool_prog_q <= RST_COOL_PROGRESS;
      window_q    <= RST_WINDOW_MS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_JUMP:      max_jump_q  <= cfg_data_i[SetW-1:0];
        CFG_CONV_TOL:      conv_tol_q  <= cfg_data_i[SetW-1:0];
        CFG_DIVERGE_LIMIT: div_lim_q   <= cfg_data_i[SetW-1:0];
        CFG_HEAT_PROGRESS: heat_prog_q <= cfg_data_i[SetW-1:0];
        CFG_COOL_PROGRESS: cool_prog_q <= cfg_data_i[SetW-1:0];
        CFG_WINDOW_MS:     window_q    <= cfg_data_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sp_q   <= s_axis_tdata[SetW-1:0];
      s1_temp_q <= s_axis_tdata[SetW+TempW-1:SetW];
      s1_now_q  <= s_axis_tdata[SetW+TempW+TimeW-1:SetW+TempW];
    end
  end

  // arithmetic on the registered sample
  always_comb begin
    prev_eff    = (prev_sp_q == '0) ? s1_temp_q : prev_temp_q;
    t_w         = WideW'(s1_temp_q);
    p_w         = WideW'(prev_eff);
    dlt         = t_w - p_w;
    adlt        = dlt[WideW-1] ? -dlt : dlt;
    jump        = adlt > $signed({3'b000, max_jump_q});
    sp_w        = $signed({3'b000, s1_sp_q});
    conv_lo     = sp_w - $signed({3'b000, conv_tol_q});
    conv_hi     = sp_w + $signed({3'b000, conv_tol_q});
    div_lo      = sp_w - $signed({3'b000, div_lim_q});
    div_hi      = sp_w + $signed({3'b000, div_lim_q});
    dl_left     = deadline_q - s1_now_q;
    win_over    = (dl_left == '0) || dl_left[TimeW-1];
    sp_change   = prev_sp_q != s1_sp_q;
    normal_mode = (mode_q == ST_OFF) || (mode_q == ST_HEAT) ||
                  (mode_q == ST_COOL) || (mode_q == ST_CONV);
  end

  // mode update: timeout, jump, progress or setpoint change, then band checks
  always_comb begin
    mode_mid   = mode_q;
    mode_d     = mode_q;
    prog_tgt_d = prog_tgt_q;
    deadline_d = deadline_q;
    if (s1_sp_q == '0) begin
      mode_d = ST_OFF;
    end else if (normal_mode) begin
      if (((mode_q == ST_HEAT) || (mode_q == ST_COOL)) && win_over) begin
        mode_mid = ST_TIMEOUT;
      end else if (jump) begin
        mode_mid = ST_JUMP;
      end else if (sp_change || ((mode_q == ST_HEAT) && (t_w >= prog_tgt_q)) ||
                   ((mode_q == ST_COOL) && (t_w <= prog_tgt_q))) begin
        if (sp_change) begin
          mode_mid = (t_w < sp_w) ? ST_HEAT : ST_COOL;
        end
        if (mode_mid == ST_HEAT) begin
          prog_tgt_d = t_w + $signed({3'b000, heat_prog_q});
        end else if (mode_mid == ST_COOL) begin
          prog_tgt_d = t_w - $signed({3'b000, cool_prog_q});
        end
        deadline_d = s1_now_q + TimeW'(window_q);
      end
      priority if ((mode_mid == ST_HEAT) && (t_w >= conv_lo)) begin
        mode_d = ST_CONV;
      end else if ((mode_mid == ST_COOL) && (t_w <= conv_hi)) begin
        mode_d = ST_CONV;
      end else if ((mode_mid == ST_CONV) && ((t_w < div_lo) || (t_w > div_hi))) begin
        mode_d = ST_DIVERGED;
      end else begin
        mode_d = mode_mid;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ST_OFF;
      prev_sp_q   <= '0;
      prev_temp_q <= '0;
      prog_tgt_q  <= '0;
      deadline_q  <= '0;
    end else if (s1_adv) begin
      mode_q      <= mode_d;
      prev_sp_q   <= s1_sp_q;
      prev_temp_q <= s1_temp_q;
      prog_tgt_q  <= prog_tgt_d;
      deadline_q  <= deadline_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= mode_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_status_q};

endmodule

@@ hw/rtl/trm_checker.sv @@
// trm_checker: port-level checks for thermal_runaway_monitor_core
// bound to thermal_runaway_monitor_core at the end of this file
// depends on trm_pkg
module trm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [trm_pkg::OutDataW-1:0]  m_axis_tdata
);
  import trm_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // the input only stalls while a result is waiting and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // a valid result carries a defined status code and zero padding
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(ST_DIVERGED) &&
                      m_axis_tdata[OutDataW-1:3] == '0)
    else $error("bad status code on output");

endmodule

bind thermal_runaway_monitor_core trm_checker u_trm_checker (.*);
